// ----- rtl/ppmfd_pkg.sv -----
// Shared types and constants for the PPM frame decoder.
// Holds the item/result payload structs and the control bundle for the width store.
// No dependencies.
package ppmfd_pkg;

	localparam int MAX_CHANNELS_DEF = 16;
	localparam int TIMER_BITS_DEF   = 32;
	localparam int TICKS_PER_US_DEF = 72;

	localparam int THR_W      = 16;
	localparam int RD_IDX_W   = 4;
	localparam int WIDTH_W    = 16;
	localparam int COUNT_W    = 5;

	localparam logic [THR_W-1:0] SYNC_RESET_US = 16'd3000;

	localparam logic KIND_CAPTURE = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [31:0]         capture_time;
		logic [RD_IDX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] pulse_width_us;
		logic [COUNT_W-1:0] channels_in_frame;
		logic               index_valid;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic rd_zero;
	} store_ctrl_t;

endpackage

// ----- rtl/ppmfd_width_store.sv -----
// Channel width store: converts a tick gap to microseconds and keeps one width per slot.
// Division by the tick rate is a reciprocal multiply; read data is registered.
// Depends on ppmfd_pkg.
module ppmfd_width_store #(
	parameter int DEPTH        = ppmfd_pkg::MAX_CHANNELS_DEF,
	parameter int GAP_W        = 24,
	parameter int TICKS_PER_US = ppmfd_pkg::TICKS_PER_US_DEF
) (
	input  logic                          clk,
	input  ppmfd_pkg::store_ctrl_t        ctrl,
	input  logic [$clog2(DEPTH)-1:0]      wr_slot,
	input  logic [GAP_W-1:0]              wr_gap,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [ppmfd_pkg::WIDTH_W-1:0] rd_data
);
	import ppmfd_pkg::*;

	localparam int LOG_T  = $clog2(TICKS_PER_US);
	localparam int SHIFT  = GAP_W + LOG_T;
	localparam int M_W    = GAP_W + 2;
	localparam int PROD_W = GAP_W + M_W;
	// ceil(2^SHIFT / TICKS_PER_US): exact floor division for any GAP_W-bit gap
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US);
	localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

	logic [WIDTH_W-1:0] mem [DEPTH];
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  quot_full;
	logic [WIDTH_W-1:0] width_us;
	logic [WIDTH_W-1:0] rd_data_q;

	assign prod      = PROD_W'(wr_gap) * PROD_W'(RECIP);
	assign quot_full = prod >> SHIFT;
	assign width_us  = quot_full[WIDTH_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_slot] <= width_us;
		end
	end

	// hold read data while the result register is stalled
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data_q <= ctrl.rd_zero ? '0 : mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/ppm_frame_decoder_core.sv -----
// Top level of the PPM frame decoder: capture bookkeeping, pipeline control, result register.
// Depends on ppmfd_pkg and ppmfd_width_store.
//
// The decoder takes one item per clock while item_stall is low. A capture item measures the
// gap to the previous capture (modulo the timer width) and either marks a frame sync or
// stores the gap in microseconds in the next channel slot; it gives no result. A read item
// returns one slot's width, the channel count of the last complete frame and a flag that the
// index lies below that count; the read passes the input register, then the result register.
// Between the two sits one reciprocal multiply (gap times ceil(2^k / TICKS_PER_US)), which
// sets the cycle's critical path; the sync limit is precomputed when the threshold is written.
// Writes to the threshold register are accepted in every cycle.
module ppm_frame_decoder_core #(
	parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF,
	parameter int TIMER_BITS   = ppmfd_pkg::TIMER_BITS_DEF,
	parameter int TICKS_PER_US = ppmfd_pkg::TICKS_PER_US_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  ppmfd_pkg::item_t            item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ppmfd_pkg::result_t          result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ppmfd_pkg::THR_W-1:0] cfg_data
);
	import ppmfd_pkg::*;

	localparam int TICK_W    = $clog2(TICKS_PER_US + 1);
	localparam int LIMIT_W   = THR_W + TICK_W;
	localparam int CMP_W     = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
	localparam int GAP_W     = (TIMER_BITS < LIMIT_W) ? TIMER_BITS : LIMIT_W;
	localparam int IDX_W     = $clog2(MAX_CHANNELS + 1);
	localparam int SLOT_W    = $clog2(MAX_CHANNELS);
	localparam int RIX_W     = ((SLOT_W > RD_IDX_W) ? SLOT_W : RD_IDX_W) + 1;
	localparam int CNT_CMP_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
	localparam logic [CNT_CMP_W-1:0] COUNT_MAX = CNT_CMP_W'((1 << COUNT_W) - 1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET =
		LIMIT_W'(SYNC_RESET_US) * LIMIT_W'(TICKS_PER_US);

	logic [LIMIT_W-1:0]    limit_q;
	logic [TIMER_BITS-1:0] prev_q;
	logic [IDX_W-1:0]      chan_idx_q;
	logic [IDX_W-1:0]      frame_cnt_q;

	logic [TIMER_BITS-1:0] now;
	logic [TIMER_BITS-1:0] gap;
	logic                  is_sync;
	logic [SLOT_W-1:0]     slot;
	logic [RIX_W-1:0]      rix;
	logic                  in_range;
	logic                  idx_ok;
	logic [CNT_CMP_W-1:0]  cnt_x;
	logic [COUNT_W-1:0]    cnt_sat;
	logic                  accept;

	logic                  valid_s1;
	logic                  kind_s1;
	logic                  store_s1;
	logic [GAP_W-1:0]      gap_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [SLOT_W-1:0]     raddr_s1;
	logic                  in_range_s1;
	logic [COUNT_W-1:0]    cnt_s1;
	logic                  iv_s1;

	logic                  valid_s2;
	logic [COUNT_W-1:0]    cnt_s2;
	logic                  iv_s2;
	logic [WIDTH_W-1:0]    width_s2;

	logic                  out_free;
	logic                  go_s1;
	store_ctrl_t           store_ctrl;

	// configuration: limit in ticks is computed once per write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= LIMIT_W'(cfg_data) * LIMIT_W'(TICKS_PER_US);
		end
	end

	// handshake and pipeline flow; captures leave stage 1 without waiting on the result side
	assign out_free   = !valid_s2 || !result_stall;
	assign go_s1      = valid_s1 && ((kind_s1 == KIND_CAPTURE) || out_free);
	assign item_stall = valid_s1 && !go_s1;
	assign accept     = item_valid && !item_stall;

	// capture decode
	assign now     = item.capture_time[TIMER_BITS-1:0];
	assign gap     = now - prev_q;
	assign is_sync = CMP_W'(gap) > CMP_W'(limit_q);
	assign slot    = (chan_idx_q == IDX_W'(MAX_CHANNELS)) ? '0 : chan_idx_q[SLOT_W-1:0];

	// read decode against the count as it stands at acceptance
	assign rix      = RIX_W'(item.read_index);
	assign in_range = rix < RIX_W'(MAX_CHANNELS);
	assign idx_ok   = in_range && (rix < RIX_W'(frame_cnt_q));
	assign cnt_x    = CNT_CMP_W'(frame_cnt_q);
	assign cnt_sat  = (cnt_x > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : cnt_x[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			chan_idx_q  <= '0;
			frame_cnt_q <= '0;
		end else if (accept && (item.kind == KIND_CAPTURE)) begin
			prev_q <= now;
			if (is_sync) begin
				frame_cnt_q <= chan_idx_q;
				chan_idx_q  <= '0;
			end else if (chan_idx_q != IDX_W'(MAX_CHANNELS)) begin
				chan_idx_q <= chan_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= item.kind;
			store_s1    <= (item.kind == KIND_CAPTURE) && !is_sync;
			gap_s1      <= gap[GAP_W-1:0];
			slot_s1     <= slot;
			raddr_s1    <= rix[SLOT_W-1:0];
			in_range_s1 <= in_range;
			cnt_s1      <= cnt_sat;
			iv_s1       <= idx_ok;
		end
	end

	assign store_ctrl.wr_en   = go_s1 && store_s1;
	assign store_ctrl.rd_en   = go_s1 && (kind_s1 == KIND_READ);
	assign store_ctrl.rd_zero = !in_range_s1;

	ppmfd_width_store #(
		.DEPTH        (MAX_CHANNELS),
		.GAP_W        (GAP_W),
		.TICKS_PER_US (TICKS_PER_US)
	) u_store (
		.clk     (clk),
		.ctrl    (store_ctrl),
		.wr_slot (slot_s1),
		.wr_gap  (gap_s1),
		.rd_addr (raddr_s1),
		.rd_data (width_s2)
	);

	// result register: load a read transaction, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (store_ctrl.rd_en) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_ctrl.rd_en) begin
			cnt_s2 <= cnt_s1;
			iv_s2  <= iv_s1;
		end
	end

	assign result_valid             = valid_s2;
	assign result.pulse_width_us    = width_s2;
	assign result.channels_in_frame = cnt_s2;
	assign result.index_valid       = iv_s2;

endmodule
